>>> hw/rtl/pse_pkg.sv
`default_nettype none
package pse_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POP  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_SAT     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t kind;
  } alu_req_t;

  typedef struct packed {
    logic    done;
    status_t status;
  } alu_rsp_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic inc;
    logic dec;
  } stk_cmd_t;

endpackage
`default_nettype wire

>>> hw/rtl/pse_tok_if.sv
`default_nettype none
interface pse_tok_if;
  logic              valid;
  logic              ready;
  logic [2:0]        op;
  logic signed [31:0] operand_value;

  modport source (output valid, output op, output operand_value, input ready);
  modport sink (input valid, input op, input operand_value, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/pse_res_if.sv
`default_nettype none
interface pse_res_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] top_value;
  logic [5:0]        depth;
  logic [2:0]        status;

  modport source (output valid, output top_value, output depth, output status, input ready);
  modport sink (input valid, input top_value, input depth, input status, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/postfix_stack_evaluator.sv
// Postfix evaluator over an operand stack, signed Q16.16 arithmetic.
// Channels: tok carries one request (op, operand_value) per valid/ready
// handshake; res returns exactly one result (top_value, depth, status) per
// request, in order. One request is in flight at a time.
// Serial ALU work per operation: push, pop, unused codes and stack errors
// use no ALU; divide by zero skips the ALU steps; add and subtract take
// 32 one-bit serial add steps; multiply 32 shift-add steps of the serial
// multiplier; divide 48 restoring quotient-bit steps.
// tok.ready rises in the same cycle the result appears in the output
// register, so a new request is taken while that result still waits.
// If res is stalled when the next result is ready, the block holds it and
// keeps tok.ready low until the output register is free.
// Reset (rst, synchronous) empties the stack and drops any pending result;
// stack contents are not cleared.
`default_nettype none
module postfix_stack_evaluator #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input wire logic clk,
  input wire logic rst,
  pse_tok_if.sink  tok,
  pse_res_if.source res
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_DEC  = 8'b00000010,
    S_RDB  = 8'b00000100,
    S_RDA  = 8'b00001000,
    S_LD   = 8'b00010000,
    S_RUN  = 8'b00100000,
    S_TOP  = 8'b01000000,
    S_EMIT = 8'b10000000
  } state_t;

  state_t            state;
  pse_pkg::op_t      op_q;
  logic [31:0]       val_q;
  logic [31:0]       b_q;
  pse_pkg::status_t  st_q;
  logic              popped;
  logic              top_zero;
  logic              res_valid;
  logic [31:0]       res_top;
  logic [5:0]        res_depth;
  logic [2:0]        res_status;

  pse_pkg::stk_cmd_t cmd;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;
  logic [31:0]       wr_data;
  logic [31:0]       rd_data;
  logic [CW-1:0]     count;
  logic [CW-1:0]     cm1;
  logic [CW-1:0]     cm2;
  logic              full;
  pse_pkg::alu_req_t areq;
  pse_pkg::alu_rsp_t arsp;
  logic [31:0]       alu_result;

  assign cm1  = count - CW'(1);
  assign cm2  = count - CW'(2);
  assign full = (count == CW'(STACK_DEPTH));

  assign tok.ready     = (state == S_IDLE) && !rst;
  assign res.valid     = res_valid;
  assign res.top_value = res_top;
  assign res.depth     = res_depth;
  assign res.status    = res_status;

  always_comb begin
    cmd       = '0;
    wr_addr   = count[AW-1:0];
    rd_addr   = cm1[AW-1:0];
    wr_data   = val_q;
    areq      = '0;
    case (op_q)
      pse_pkg::OP_ADD: areq.kind = pse_pkg::ALU_ADD;
      pse_pkg::OP_SUB: areq.kind = pse_pkg::ALU_SUB;
      pse_pkg::OP_MUL: areq.kind = pse_pkg::ALU_MUL;
      default:         areq.kind = pse_pkg::ALU_DIV;
    endcase
    case (state)
      S_DEC: begin
        case (op_q)
          pse_pkg::OP_PUSH: begin
            cmd.wr_en = !full;
            cmd.inc   = !full;
          end
          pse_pkg::OP_POP: begin
            cmd.dec = (count != '0);
          end
          default: begin
          end
        endcase
      end
      S_RDB: begin
        cmd.rd_en = 1'b1;
      end
      S_RDA: begin
        cmd.rd_en = 1'b1;
        rd_addr   = cm2[AW-1:0];
      end
      S_LD: begin
        areq.start = 1'b1;
      end
      S_RUN: begin
        cmd.wr_en = arsp.done;
        cmd.dec   = arsp.done;
        wr_addr   = cm2[AW-1:0];
        wr_data   = alu_result;
      end
      S_TOP: begin
        cmd.rd_en = popped || (count != '0);
        rd_addr   = popped ? count[AW-1:0] : cm1[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && state != S_EMIT) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tok.valid) begin
            op_q   <= pse_pkg::op_t'(tok.op);
            val_q  <= tok.operand_value;
            popped <= 1'b0;
            st_q   <= pse_pkg::ST_OK;
            state  <= S_DEC;
          end
        end
        S_DEC: begin
          state <= S_TOP;
          case (op_q)
            pse_pkg::OP_PUSH: begin
              if (full) begin
                st_q <= pse_pkg::ST_FULL;
              end
            end
            pse_pkg::OP_ADD, pse_pkg::OP_SUB, pse_pkg::OP_MUL, pse_pkg::OP_DIV: begin
              if (count < CW'(2)) begin
                st_q <= pse_pkg::ST_EMPTY;
              end else begin
                state <= S_RDB;
              end
            end
            pse_pkg::OP_POP: begin
              if (count == '0) begin
                st_q <= pse_pkg::ST_EMPTY;
              end else begin
                popped <= 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        S_RDB: begin
          state <= S_RDA;
        end
        S_RDA: begin
          b_q   <= rd_data;
          state <= S_LD;
        end
        S_LD: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (arsp.done) begin
            st_q  <= arsp.status;
            state <= S_TOP;
          end
        end
        S_TOP: begin
          top_zero <= !popped && (count == '0);
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (!res_valid || res.ready) begin
            res_top    <= top_zero ? 32'd0 : rd_data;
            res_depth  <= 6'(count);
            res_status <= st_q;
            res_valid  <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  pse_stack #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .count   (count)
  );

  pse_serial_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (areq),
    .a      (rd_data),
    .b      (b_q),
    .rsp    (arsp),
    .result (alu_result)
  );

endmodule
`default_nettype wire

>>> hw/rtl/pse_stack.sv
`default_nettype none
module pse_stack #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF,
  localparam int AW = $clog2(STACK_DEPTH),
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pse_pkg::stk_cmd_t cmd,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [31:0]      wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [31:0]      rd_data,
  output logic      [CW-1:0]    count
);

  logic [31:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.inc) begin
      count <= count + CW'(1);
    end else if (cmd.dec) begin
      count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pse_serial_alu.sv
`default_nettype none
module pse_serial_alu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pse_pkg::alu_req_t req,
  input  wire logic [31:0]       a,
  input  wire logic [31:0]       b,
  output pse_pkg::alu_rsp_t      rsp,
  output logic [31:0]            result
);

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_ADD  = 6'b000010,
    A_MUL  = 6'b000100,
    A_DIV  = 6'b001000,
    A_RND  = 6'b010000,
    A_FIX  = 6'b100000
  } alu_state_t;

  alu_state_t       state;
  pse_pkg::alu_op_t kind;
  logic [5:0]       cnt;
  logic [31:0]      x;
  logic [31:0]      y;
  logic [63:0]      w;
  logic [32:0]      r;
  logic             c;
  logic             neg;
  logic             sa;
  logic             sb;
  logic             dz;
  logic             done;
  pse_pkg::status_t status;

  logic             sum_bit;
  logic             carry_next;
  logic [32:0]      mul_sum;
  logic [32:0]      div_t;
  logic             div_ge;
  logic [47:0]      qmag;
  logic [31:0]      sum;
  logic             ovf;
  logic [31:0]      fix_val;
  pse_pkg::status_t fix_st;

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  assign sum_bit    = x[0] ^ y[0] ^ c;
  assign carry_next = (x[0] & y[0]) | (c & (x[0] ^ y[0]));
  assign mul_sum    = {1'b0, w[63:32]} + (w[0] ? {1'b0, x} : 33'd0);
  assign div_t      = {r[31:0], w[47]};
  assign div_ge     = div_t >= {1'b0, y};
  assign qmag       = (kind == pse_pkg::ALU_MUL) ?
                      (w[63:16] + 48'(neg && (w[15:0] != 16'd0))) : w[47:0];
  assign sum        = w[63:32];
  assign ovf        = (sa == sb) && (sum[31] != sa);

  always_comb begin
    fix_val = w[31:0];
    fix_st  = pse_pkg::ST_OK;
    if (dz) begin
      fix_val = sa ? pse_pkg::Q_MIN : pse_pkg::Q_MAX;
      fix_st  = pse_pkg::ST_DIVZERO;
    end else if (kind == pse_pkg::ALU_ADD || kind == pse_pkg::ALU_SUB) begin
      fix_val = sum;
      if (ovf) begin
        fix_val = sa ? pse_pkg::Q_MIN : pse_pkg::Q_MAX;
        fix_st  = pse_pkg::ST_SAT;
      end
    end else if (neg) begin
      if (w[47:0] > 48'h0000_8000_0000) begin
        fix_val = pse_pkg::Q_MIN;
        fix_st  = pse_pkg::ST_SAT;
      end else begin
        fix_val = ~w[31:0] + 32'd1;
      end
    end else if (w[47:0] > 48'h0000_7FFF_FFFF) begin
      fix_val = pse_pkg::Q_MAX;
      fix_st  = pse_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        A_IDLE: begin
          if (req.start) begin
            kind <= req.kind;
            cnt  <= '0;
            dz   <= 1'b0;
            sa   <= a[31];
            neg  <= a[31] ^ b[31];
            case (req.kind)
              pse_pkg::ALU_ADD, pse_pkg::ALU_SUB: begin
                x     <= a;
                y     <= (req.kind == pse_pkg::ALU_SUB) ? ~b : b;
                c     <= (req.kind == pse_pkg::ALU_SUB);
                sb    <= (req.kind == pse_pkg::ALU_SUB) ? ~b[31] : b[31];
                state <= A_ADD;
              end
              pse_pkg::ALU_MUL: begin
                x     <= mag(a);
                w     <= {32'd0, mag(b)};
                state <= A_MUL;
              end
              default: begin
                y <= mag(b);
                w <= {16'd0, mag(a), 16'd0};
                r <= '0;
                if (b == 32'd0) begin
                  dz    <= 1'b1;
                  state <= A_FIX;
                end else begin
                  state <= A_DIV;
                end
              end
            endcase
          end
        end
        A_ADD: begin
          x   <= x >> 1;
          y   <= y >> 1;
          c   <= carry_next;
          w   <= {sum_bit, w[63:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            state <= A_FIX;
          end
        end
        A_MUL: begin
          w   <= {mul_sum, w[31:1]};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd31) begin
            state <= A_RND;
          end
        end
        A_DIV: begin
          r         <= div_ge ? (div_t - {1'b0, y}) : div_t;
          w[47:0]   <= {w[46:0], div_ge};
          cnt       <= cnt + 6'd1;
          if (cnt == 6'd47) begin
            state <= A_RND;
          end
        end
        A_RND: begin
          w[47:0] <= qmag;
          state   <= A_FIX;
        end
        A_FIX: begin
          result <= fix_val;
          status <= fix_st;
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  assign rsp.done   = done;
  assign rsp.status = status;

endmodule
`default_nettype wire

>>> hw/rtl/pse_checker.sv
`default_nettype none
module pse_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        tok_valid,
  input wire logic        tok_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] res_top_value,
  input wire logic [5:0]  res_depth,
  input wire logic [2:0]  res_status
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_top_value) &&
      $stable(res_depth) && $stable(res_status))
    else $error("result changed or dropped while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_ready |=> !tok_ready)
    else $error("second request taken while one is in flight");

  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_ready && !res_valid |=> !res_valid ##1 !res_valid)
    else $error("result appeared too soon after request");

  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!tok_ready))
    else $error("result loaded while block was idle");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (
  .clk           (clk),
  .rst           (rst),
  .tok_valid     (tok.valid),
  .tok_ready     (tok.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_top_value (res.top_value),
  .res_depth     (res.depth),
  .res_status    (res.status)
);
`default_nettype wire
